// ===== design/srd_pkg.sv =====
package srd_pkg;

    // default size of the largest frame, header and checksum included
    localparam int MAX_FRAME_BYTES_DEF = 64;

    // header marker and reset value of the length limit
    localparam logic [7:0] HDR_BYTE     = 8'hFF;
    localparam logic [7:0] MAX_LEN_RST  = 8'd60;
    // smallest length that carries a data word
    localparam logic [7:0] WORD_MIN_LEN = 8'd4;

    // widths of the data words on the master and slave sides
    localparam int OUT_DATA_W = 48;
    localparam int IN_DATA_W  = 8;

    // one completed frame, as handed from the frame core to the output stage
    typedef struct packed {
        logic        valid;
        logic [7:0]  servo_id;
        logic [7:0]  body_length;
        logic [7:0]  status_byte;
        logic [15:0] data_word;
        logic        data_word_present;
        logic        checksum_ok;
    } t_frame_result;

    // handshake state of the input register towards the core
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_in_word;

endpackage

// ===== design/srd_in_stage.sv =====
module srd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_step,
    output srd_pkg::t_in_word o_word
);
    import srd_pkg::*;

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // room when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_step;

    // load a new word, or drop the held one once it has been used
    always_comb begin
        n_valid = r_valid;
        n_byte  = r_byte;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            n_byte  = i_rx_byte;
        end else if (i_step) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_byte <= n_byte;
    end

    assign o_word.valid   = r_valid;
    assign o_word.rx_byte = r_byte;

endmodule

// ===== design/srd_frame_core.sv =====
module srd_frame_core #(
    parameter int MAX_FRAME_BYTES = srd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_max_body_length,
    output srd_pkg::t_frame_result o_result
);
    import srd_pkg::*;

    // hard cap on the length byte from the frame size
    localparam logic [7:0] LenCap = 8'(MAX_FRAME_BYTES - 4);

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HUNT_FF = 5'b00010,
        PH_ID      = 5'b00100,
        PH_LEN     = 5'b01000,
        PH_BODY    = 5'b10000
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_id,     n_id;
    logic [7:0]  r_len,    n_len;
    logic [7:0]  r_pos,    n_pos;
    logic [7:0]  r_sum,    n_sum;
    logic [7:0]  r_status, n_status;
    logic [15:0] r_word,   n_word;

    logic [7:0]  lim;
    logic        last_byte;
    logic        present;

    // effective limit is the smaller of register and frame cap
    assign lim       = (i_max_body_length < LenCap) ? i_max_body_length : LenCap;
    assign last_byte = !(({1'b0, r_pos} + 9'd1) < {1'b0, r_len});

    // next state of the deframer for the byte in the input register
    always_comb begin
        n_phase  = r_phase;
        n_id     = r_id;
        n_len    = r_len;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_status = r_status;
        n_word   = r_word;
        case (r_phase)
            PH_HUNT_FF: begin
                n_phase = (i_rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT;
            end
            PH_ID: begin
                n_id    = i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_rx_byte == 8'd0 || i_rx_byte > lim) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_len    = i_rx_byte;
                    n_pos    = 8'd0;
                    n_sum    = r_id + i_rx_byte;
                    n_status = 8'd0;
                    n_word   = 16'd0;
                    n_phase  = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_pos == 8'd0) begin
                    n_status = i_rx_byte;
                end else if (r_pos == 8'd1) begin
                    n_word[7:0] = i_rx_byte;
                end else if (r_pos == 8'd2) begin
                    n_word[15:8] = i_rx_byte;
                end
                if (!last_byte) begin
                    n_sum = r_sum + i_rx_byte;
                    n_pos = r_pos + 8'd1;
                end else begin
                    n_pos   = 8'd0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                // hunting, and any stray code acts the same
                n_phase = (i_rx_byte == HDR_BYTE) ? PH_HUNT_FF : PH_HUNT;
            end
        endcase
    end

    // state advances only when a word is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_id     <= 8'd0;
            r_len    <= 8'd0;
            r_pos    <= 8'd0;
            r_sum    <= 8'd0;
            r_status <= 8'd0;
            r_word   <= 16'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_id     <= n_id;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_status <= n_status;
            r_word   <= n_word;
        end
    end

    // result of the frame end, status and word taken from the updated copies
    assign present = (r_len >= WORD_MIN_LEN);

    assign o_result.valid             = i_step && (r_phase == PH_BODY) && last_byte;
    assign o_result.servo_id          = r_id;
    assign o_result.body_length       = r_len;
    assign o_result.status_byte       = n_status;
    assign o_result.data_word         = present ? n_word : 16'd0;
    assign o_result.data_word_present = present;
    assign o_result.checksum_ok       = (~r_sum == i_rx_byte);

endmodule

// ===== design/srd_out_stage.sv =====
module srd_out_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  srd_pkg::t_frame_result           i_result,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [srd_pkg::OUT_DATA_W-1:0]   o_data,
    output logic                             o_space
);
    import srd_pkg::*;

    logic          r_valid;
    logic          n_valid;
    t_frame_result r_res;

    // free when empty or emptied this cycle
    assign o_space = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_space) begin
            n_valid = i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_space && i_result.valid) begin
            r_res <= i_result;
        end
    end

    // pack the result word, first field lowest
    assign o_valid = r_valid;
    assign o_data  = {6'd0, r_res.checksum_ok, r_res.data_word_present, r_res.data_word,
                      r_res.status_byte, r_res.body_length, r_res.servo_id};

endmodule

// ===== design/servo_reply_deframer_unit.sv =====
// channel   | dir | payload
// ----------+-----+-----------------------------------------------------------
// s (rx)    | in  | tdata[7:0] rx_byte
// m (frame) | out | tdata: id, length, status, data word, present, checksum ok
// cfg       | in  | wr_data[7:0] max_body_length, written on wr_en
//
// One received byte is taken per cycle while the master side does not stall;
// each byte is held in the input register, and a frame result is registered in
// the output register when its checksum byte moves on from the input register.
// Reset is synchronous and active low; it clears the phase and both registers
// and sets the length limit to 60.
// A stall on the master side backs up through the input register to s tready.
module servo_reply_deframer_unit #(
    parameter int MAX_FRAME_BYTES = srd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [7:0] rx_byte
    input  logic [srd_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] servo_id, [15:8] body_length, [23:16] status_byte,
    // [39:24] data_word, [40] data_word_present, [41] checksum_ok, [47:42] zero
    output logic [srd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [7:0]                        i_cfg_wr_data
);
    import srd_pkg::*;

    logic          r_max_len;
    logic [7:0]    r_max_body_length;
    t_in_word      in_word;
    t_frame_result result;
    logic          out_space;
    logic          step;

    // length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_length <= MAX_LEN_RST;
            r_max_len         <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_max_body_length <= i_cfg_wr_data;
            r_max_len         <= 1'b1;
        end
    end

    // a held word moves into the core when the result register has room
    assign step = in_word.valid && out_space;

    srd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_rx_byte (i_s_tdata),
        .i_step    (step),
        .o_word    (in_word)
    );

    srd_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_rx_byte         (in_word.rx_byte),
        .i_max_body_length (r_max_len ? r_max_body_length : MAX_LEN_RST),
        .o_result          (result)
    );

    srd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata),
        .o_space  (out_space)
    );

endmodule

// ===== design/srd_checker.sv =====
module srd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [srd_pkg::OUT_DATA_W-1:0] i_m_tdata
);
    import srd_pkg::*;

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result offered right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("stalled result changed");

    // presence flag follows the length
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[40] == (i_m_tdata[15:8] >= WORD_MIN_LEN)))
        else $error("data word presence does not match length");

    // absent word reads as zero, padding is zero
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((i_m_tdata[40] || i_m_tdata[39:24] == 16'd0)
                        && i_m_tdata[47:42] == 6'd0))
        else $error("absent data word or padding not zero");

    // only lengths in range ever complete a frame
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[15:8] != 8'd0 && i_m_tdata[15:8] <= 8'd252))
        else $error("frame length out of range");

endmodule

bind servo_reply_deframer_unit srd_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
